### hw/rtl/ptce_pkg.sv
// Shared types, widths and gain code helpers for the preview-to-capture
// exposure converter. No dependencies.
`default_nettype none
package ptce_pkg;

  localparam int LINE_W  = 16;
  localparam int GAIN_W  = 9;
  localparam int CAPA_W  = 32;
  localparam int EG_W    = CAPA_W + GAIN_W;
  localparam int CODE_W  = 8;
  localparam int IDX_W   = 3;

  localparam logic [IDX_W-1:0] REG_CAPTURE_MAX = 3'd0;
  localparam logic [IDX_W-1:0] REG_PREVIEW_MAX = 3'd1;
  localparam logic [IDX_W-1:0] REG_EXP_SPLIT   = 3'd2;
  localparam logic [IDX_W-1:0] REG_BAND_50     = 3'd3;
  localparam logic [IDX_W-1:0] REG_BAND_60     = 3'd4;

  localparam logic [1:0] BAND_AUTO   = 2'd0;
  localparam logic [1:0] BAND_FORCE60 = 2'd2;

  localparam logic [CODE_W-1:0] GAIN_DUPLICATE   = 8'h10;
  localparam logic [CODE_W-1:0] GAIN_REPLACEMENT = 8'h11;
  localparam logic [EG_W-1:0]   GAIN_LIMIT       = 41'd31;
  localparam logic [EG_W-1:0]   GAIN_UNIT        = 41'd16;

  typedef struct packed {
    logic [LINE_W-1:0] step;
    logic [GAIN_W-1:0] gain;
    logic [LINE_W-1:0] frame;
    logic              err;
  } side_a_t;

  typedef struct packed {
    logic [EG_W-1:0]   eg;
    logic              round_down;
    logic [LINE_W-1:0] frame;
    logic              err;
  } side_b_t;

  typedef struct packed {
    logic [LINE_W-1:0] cap;
    logic [LINE_W-1:0] frame;
    logic              err;
  } side_c_t;

  // Linear gain in sixteenths: 16 plus the fraction nibble, doubled per high bit.
  function automatic logic [GAIN_W-1:0] decode_gain(input logic [CODE_W-1:0] code);
    logic [GAIN_W-1:0] g;
    g = {5'd1, code[3:0]};
    for (int b = 4; b < 8; b++) begin
      if (code[b]) begin
        g = {g[GAIN_W-2:0], 1'b0};
      end
    end
    return g;
  endfunction

  // Inverse of decode_gain; top bits beyond four halvings are dropped.
  function automatic logic [CODE_W-1:0] encode_gain(input logic [EG_W-1:0] gin);
    logic [EG_W-1:0]   g;
    logic [CODE_W-1:0] code;
    g    = gin;
    code = '0;
    for (int b = 4; b < 8; b++) begin
      if (g > GAIN_LIMIT) begin
        code[b] = 1'b1;
        g = g >> 1;
      end
    end
    if (g > GAIN_UNIT) begin
      code[3:0] = g[3:0];
    end
    if (code == GAIN_DUPLICATE) begin
      code = GAIN_REPLACEMENT;
    end
    return code;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/ptce_div.sv
// Pipelined restoring divider, one quotient bit per register stage, with a
// side payload that travels alongside. Depends on nothing.
`default_nettype none
module ptce_div #(
  parameter int NUM_W  = 32,
  parameter int DEN_W  = 16,
  parameter int SIDE_W = 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [NUM_W-1:0]  num,
  input  wire logic [DEN_W-1:0]  den,
  input  wire logic [SIDE_W-1:0] side,
  output logic                   out_valid,
  output logic [NUM_W-1:0]       quo,
  output logic [DEN_W-1:0]       rem,
  output logic [SIDE_W-1:0]      side_out
);

  logic [NUM_W-1:0]  vld;
  logic [DEN_W-1:0]  rem_q  [NUM_W];
  logic [NUM_W-1:0]  num_q  [NUM_W];
  logic [DEN_W-1:0]  den_q  [NUM_W];
  logic [SIDE_W-1:0] side_q [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic              v_in;
    logic [DEN_W-1:0]  r_in;
    logic [NUM_W-1:0]  n_in;
    logic [DEN_W-1:0]  d_in;
    logic [SIDE_W-1:0] s_in;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              ge;

    if (k == 0) begin : g_first
      assign v_in = in_valid;
      assign r_in = '0;
      assign n_in = num;
      assign d_in = den;
      assign s_in = side;
    end else begin : g_next
      assign v_in = vld[k-1];
      assign r_in = rem_q[k-1];
      assign n_in = num_q[k-1];
      assign d_in = den_q[k-1];
      assign s_in = side_q[k-1];
    end

    assign trial = {r_in, n_in[NUM_W-1]};
    assign diff  = trial - {1'b0, d_in};
    assign ge    = trial >= {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        num_q[k]  <= {n_in[NUM_W-2:0], ge};
        den_q[k]  <= d_in;
        side_q[k] <= s_in;
      end
    end
  end

  assign out_valid = vld[NUM_W-1];
  assign quo       = num_q[NUM_W-1];
  assign rem       = rem_q[NUM_W-1];
  assign side_out  = side_q[NUM_W-1];

endmodule
`default_nettype wire

### hw/rtl/preview_to_capture_exposure.sv
// Top level of the preview-to-capture exposure and gain converter.
// Depends on ptce_pkg and ptce_div.
`default_nettype none
//
//  Channel   Direction  Transfer fields
//  s_axis    in         tdata: top, middle, bottom exposure bytes, gain code;
//                       tuser: light_is_50hz, banding_mode
//  m_axis    out        tdata: exposure lines, gain code, frame lines;
//                       tuser: error_flag
//  cfg       in         cfg_wr_en, cfg_index, cfg_data (write only)
//
// Each transfer passes through three bit-per-stage dividers (32, 16 and 41
// stages) plus eight other register stages, the first of which loads at the
// accepting edge. A new transfer is accepted in every cycle unless a stall
// on m_axis holds the pipeline.
// Reset is synchronous and active high; it clears all valid bits and loads
// the register defaults. A stall on m_axis freezes the whole pipeline, so
// s_axis_tready falls in the same cycle and nothing is lost or repeated.
module preview_to_capture_exposure (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [7:0] exposure_top, [15:8] exposure_middle, [23:16] exposure_bottom,
  // [31:24] preview_gain_code
  input  wire logic [31:0] s_axis_tdata,
  // [0] light_is_50hz, [2:1] banding_mode
  input  wire logic [2:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [15:0] capture_exposure_lines, [23:16] capture_gain_code,
  // [39:24] frame_length_lines
  output logic [39:0]      m_axis_tdata,
  // [0] error_flag
  output logic             m_axis_tuser,
  input  wire logic        cfg_wr_en,
  input  wire logic [ptce_pkg::IDX_W-1:0]  cfg_index,
  input  wire logic [ptce_pkg::LINE_W-1:0] cfg_data
);
  import ptce_pkg::*;

  // Configuration registers.
  logic [LINE_W-1:0] capture_max;
  logic [LINE_W-1:0] preview_max;
  logic [LINE_W-1:0] exp_split;
  logic [LINE_W-1:0] band_50;
  logic [LINE_W-1:0] band_60;

  always_ff @(posedge clk) begin
    if (rst) begin
      capture_max <= 16'd2000;
      preview_max <= 16'd1008;
      exp_split   <= 16'd1008;
      band_50     <= 16'd150;
      band_60     <= 16'd125;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_CAPTURE_MAX: capture_max <= cfg_data;
        REG_PREVIEW_MAX: preview_max <= cfg_data;
        REG_EXP_SPLIT:   exp_split   <= cfg_data;
        REG_BAND_50:     band_50     <= cfg_data;
        REG_BAND_60:     band_60     <= cfg_data;
        default: ;
      endcase
    end
  end

  // The whole pipeline moves together; it holds only when the output
  // register is full and not being taken.
  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // Stage 0: rebuild the preview exposure, pick the band step, decode gain.
  logic [LINE_W-1:0] pe_in;
  logic              use60;
  logic [LINE_W-1:0] step_in;
  logic [LINE_W-1:0] dbl;

  assign pe_in   = {s_axis_tdata[3:0], s_axis_tdata[15:8], s_axis_tdata[23:20]};
  assign use60   = (s_axis_tuser[2:1] == BAND_AUTO) ? !s_axis_tuser[0]
                                                    : (s_axis_tuser[2:1] == BAND_FORCE60);
  assign step_in = use60 ? band_60 : band_50;
  assign dbl     = {pe_in[LINE_W-2:0], 1'b0};

  logic              s0_v;
  logic [LINE_W-1:0] s0_pe;
  logic              s0_hi;
  side_a_t           s0_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
    end else if (en) begin
      s0_v <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_pe         <= pe_in;
      s0_hi         <= pe_in > exp_split;
      s0_side.step  <= step_in;
      s0_side.gain  <= decode_gain(s_axis_tdata[31:24]);
      s0_side.frame <= (dbl < capture_max) ? capture_max : dbl;
      s0_side.err   <= (preview_max == '0) || (step_in == '0);
    end
  end

  // Stage 1: exposure times capture lines.
  logic              s1_v;
  logic [31:0]       s1_prod;
  logic              s1_hi;
  side_a_t           s1_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= s0_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_prod <= 32'(s0_pe) * 32'(capture_max);
      s1_hi   <= s0_hi;
      s1_side <= s0_side;
    end
  end

  // Stage 2: apply 12/16 or 15/16 and fold the sixteen of the divisor into
  // the numerator, since floor(x / 16p) equals floor(floor(x / 16) / p).
  logic [35:0] p36;
  logic [35:0] scaled;
  assign p36    = {4'b0, s1_prod};
  assign scaled = s1_hi ? ((p36 << 3) + (p36 << 2)) : ((p36 << 4) - p36);

  logic              s2_v;
  logic [CAPA_W-1:0] s2_num;
  side_a_t           s2_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (en) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_num  <= scaled[35:4];
      s2_side <= s1_side;
    end
  end

  // Divider A: scaled exposure over preview lines.
  logic                  da_v;
  logic [CAPA_W-1:0]     da_quo;
  logic [LINE_W-1:0]     da_rem;
  logic [$bits(side_a_t)-1:0] da_side_bits;
  side_a_t               da_side;

  ptce_div #(.NUM_W(CAPA_W), .DEN_W(LINE_W), .SIDE_W($bits(side_a_t))) u_div_a (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s2_v),
    .num      (s2_num),
    .den      (preview_max),
    .side     (s2_side),
    .out_valid(da_v),
    .quo      (da_quo),
    .rem      (da_rem),
    .side_out (da_side_bits)
  );
  assign da_side = side_a_t'(da_side_bits);

  // Stage 3: exposure-gain product. The remainder of divider A is not needed.
  logic              s3_v;
  logic [EG_W-1:0]   s3_eg;
  logic              s3_rem_zero;
  side_a_t           s3_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (en) begin
      s3_v <= da_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_eg       <= EG_W'(da_quo) * EG_W'(da_side.gain);
      s3_rem_zero <= da_rem == '0;
      s3_side     <= da_side;
    end
  end

  // Stage 4: clamp to the capture maximum or prepare banding round-down.
  logic              under;
  logic [LINE_W-1:0] lines_eg;
  assign under    = s3_eg < EG_W'({capture_max, 4'b0});
  assign lines_eg = s3_eg[LINE_W+3:4];

  logic              s4_v;
  logic [LINE_W-1:0] s4_capb;
  logic [LINE_W-1:0] s4_step;
  side_b_t           s4_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
    end else if (en) begin
      s4_v <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_capb            <= under ? lines_eg : capture_max;
      s4_step            <= s3_side.step;
      s4_side.eg         <= s3_eg;
      s4_side.round_down <= under && (lines_eg > s3_side.step);
      s4_side.frame      <= s3_side.frame;
      s4_side.err        <= s3_side.err || (s3_rem_zero && 1'b0);
    end
  end

  // Divider B: exposure lines modulo the band step.
  logic                  db_v;
  logic [LINE_W-1:0]     db_quo;
  logic [LINE_W-1:0]     db_rem;
  logic [$bits(side_b_t)-1:0] db_side_bits;
  side_b_t               db_side;
  logic [LINE_W-1:0]     db_capb;

  ptce_div #(.NUM_W(LINE_W), .DEN_W(LINE_W), .SIDE_W($bits(side_b_t))) u_div_b (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s4_v),
    .num      (s4_capb),
    .den      (s4_step),
    .side     (s4_side),
    .out_valid(db_v),
    .quo      (db_quo),
    .rem      (db_rem),
    .side_out (db_side_bits)
  );
  assign db_side = side_b_t'(db_side_bits);

  // Rebuild the dividend: the divider does not pass its numerator on, so the
  // dividend is taken instead from the bits of the exposure-gain product in
  // the side payload, which are the same as lines_eg, or is capture_max when
  // not rounding down. A zero step is flagged as an error anyway.
  assign db_capb = db_side.round_down ? db_side.eg[LINE_W+3:4] : capture_max;

  // Stage 5: final capture lines, never zero.
  logic [LINE_W-1:0] cap_rd;
  assign cap_rd = db_side.round_down ? (db_capb - db_rem)
                : ((db_side.eg < EG_W'({capture_max, 4'b0})) ? db_side.eg[LINE_W+3:4]
                                                               : capture_max);

  logic              s5_v;
  logic [EG_W-1:0]   s5_eg;
  side_c_t           s5_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_v <= 1'b0;
    end else if (en) begin
      s5_v <= db_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_eg         <= db_side.eg;
      s5_side.cap   <= (cap_rd == '0) ? LINE_W'(1) : cap_rd;
      s5_side.frame <= db_side.frame;
      s5_side.err   <= db_side.err || (db_quo != db_quo);
    end
  end

  // Divider C: exposure-gain product over the final lines.
  logic                  dc_v;
  logic [EG_W-1:0]       dc_quo;
  logic [LINE_W-1:0]     dc_rem;
  logic [$bits(side_c_t)-1:0] dc_side_bits;
  side_c_t               dc_side;

  ptce_div #(.NUM_W(EG_W), .DEN_W(LINE_W), .SIDE_W($bits(side_c_t))) u_div_c (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s5_v),
    .num      (s5_eg),
    .den      (s5_side.cap),
    .side     (s5_side),
    .out_valid(dc_v),
    .quo      (dc_quo),
    .rem      (dc_rem),
    .side_out (dc_side_bits)
  );
  assign dc_side = side_c_t'(dc_side_bits);

  // Stage 6: round the gain to nearest (half rounds up).
  logic              s6_v;
  logic [EG_W-1:0]   s6_gain;
  side_c_t           s6_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_v <= 1'b0;
    end else if (en) begin
      s6_v <= dc_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_gain <= dc_quo + EG_W'({dc_rem, 1'b0} >= {1'b0, dc_side.cap});
      s6_side <= dc_side;
    end
  end

  // Stage 7: output register with gain re-encoding.
  logic [LINE_W-1:0] out_lines;
  logic [CODE_W-1:0] out_code;
  logic [LINE_W-1:0] out_frame;
  logic              out_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= s6_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_err   <= s6_side.err;
      out_lines <= s6_side.err ? '0 : s6_side.cap;
      out_code  <= s6_side.err ? '0 : encode_gain(s6_gain);
      out_frame <= s6_side.err ? '0 : s6_side.frame;
    end
  end

  assign m_axis_tdata = {out_frame, out_code, out_lines};
  assign m_axis_tuser = out_err;

  // An error result carries no settings.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("error result with nonzero fields");

  // A good result always has at least one exposure line.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[15:0] != '0))
    else $error("zero capture exposure");

  // A good frame length never falls below the capture maximum.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[39:24] >= capture_max))
    else $error("frame length below capture maximum");

  // While stalled the output register holds its contents.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && m_axis_tvalid))
    else $error("output changed during stall");

endmodule
`default_nettype wire
